/* hw/rtl/lcgrr_pkg.sv */
// Shared constants and types for the LCG range generator.
// Used by lcgrr_divider and lcg_random_range_generator_unit; depends on nothing.
package lcgrr_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned CNT_W  = $clog2(WORD_W);

    localparam logic [WORD_W-1:0] LCG_MULTIPLIER = 32'd1103515245;
    localparam logic [WORD_W-1:0] LCG_INCREMENT  = 32'd12345;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_STEP,
        ST_DIV,
        ST_FINISH
    } seq_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

/* hw/rtl/lcgrr_divider.sv */
// Restoring unsigned remainder unit, one quotient bit per cycle.
// Depends on lcgrr_pkg for the word width and status struct.
module lcgrr_divider
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  lcgrr_pkg::word_t     dividend,
    input  lcgrr_pkg::word_t     divisor,
    output lcgrr_pkg::div_status_t status,
    output lcgrr_pkg::word_t     remainder
);

    localparam logic [lcgrr_pkg::CNT_W-1:0] LAST_COUNT = {lcgrr_pkg::CNT_W{1'b1}};

    logic                         busy_reg;
    logic                         done_reg;
    logic [lcgrr_pkg::CNT_W-1:0]  count_reg;
    lcgrr_pkg::word_t             rem_reg;
    lcgrr_pkg::word_t             quo_reg;
    lcgrr_pkg::word_t             dsr_reg;

    logic [lcgrr_pkg::WORD_W:0]   trial;
    logic [lcgrr_pkg::WORD_W:0]   diff;
    lcgrr_pkg::word_t             rem_next;

    always_comb
    begin
        trial = {rem_reg, quo_reg[lcgrr_pkg::WORD_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        if (diff[lcgrr_pkg::WORD_W])
        begin
            rem_next = trial[lcgrr_pkg::WORD_W-1:0];
        end
        else
        begin
            rem_next = diff[lcgrr_pkg::WORD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + 1'b1;
                if (count_reg == LAST_COUNT)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[lcgrr_pkg::WORD_W-2:0], 1'b0};
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign remainder   = rem_reg;

endmodule

/* hw/rtl/lcg_random_range_generator_unit.sv */
// Top level of the LCG range generator: sequencer, state step and output register.
// Depends on lcgrr_pkg and lcgrr_divider.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  input    | in_valid / in_ready  | range_begin, range_end
//  output   | out_valid / out_ready| raw_value, ranged_value, range_empty
//  config   | cfg_valid / cfg_ready| seed_value
//
// An item passes from acceptance to a loaded result in order: one multiply, one
// add of the increment, the remainder unit (one quotient bit at a time), and the
// load of the output register. in_ready is high only while the sequencer is idle.
// Reset clears the generator state to zero. A stalled result holds in the output
// register; the next item is accepted meanwhile and waits in the final step until
// the register is free.
module lcg_random_range_generator_unit
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [31:0]      range_begin,
    input  logic signed [31:0]      range_end,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [31:0]             raw_value,
    output logic signed [31:0]      ranged_value,
    output logic                    range_empty,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [31:0]             seed_value
);

    lcgrr_pkg::seq_state_t   state_reg;
    lcgrr_pkg::seq_state_t   state_next;

    lcgrr_pkg::word_t        gen_reg;
    lcgrr_pkg::word_t        prod_reg;
    lcgrr_pkg::word_t        begin_reg;
    lcgrr_pkg::word_t        end_reg;
    lcgrr_pkg::word_t        dsr_reg;
    lcgrr_pkg::word_t        gen_next;
    lcgrr_pkg::word_t        dsr_next;

    logic                    out_valid_reg;
    lcgrr_pkg::word_t        raw_reg;
    lcgrr_pkg::word_t        ranged_reg;
    logic                    empty_reg;

    logic                    accept_in;
    logic                    div_start;
    logic                    load_out;
    lcgrr_pkg::div_status_t  div_status;
    lcgrr_pkg::word_t        div_rem;

    assign accept_in = in_valid && in_ready;
    assign gen_next  = prod_reg + lcgrr_pkg::LCG_INCREMENT;
    assign dsr_next  = end_reg - begin_reg;

    lcgrr_divider u_divider
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (gen_next),
        .divisor   (dsr_next),
        .status    (div_status),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lcgrr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        div_start  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            lcgrr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = lcgrr_pkg::ST_MUL;
                end
            end
            lcgrr_pkg::ST_MUL:
            begin
                state_next = lcgrr_pkg::ST_STEP;
            end
            lcgrr_pkg::ST_STEP:
            begin
                div_start  = 1'b1;
                state_next = lcgrr_pkg::ST_DIV;
            end
            lcgrr_pkg::ST_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = lcgrr_pkg::ST_FINISH;
                end
            end
            lcgrr_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = lcgrr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lcgrr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                gen_reg <= seed_value;
            end
            else if (state_reg == lcgrr_pkg::ST_STEP)
            begin
                gen_reg <= gen_next;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            begin_reg <= range_begin;
            end_reg   <= range_end;
        end
        if (state_reg == lcgrr_pkg::ST_MUL)
        begin
            prod_reg <= gen_reg * lcgrr_pkg::LCG_MULTIPLIER;
        end
        if (state_reg == lcgrr_pkg::ST_STEP)
        begin
            dsr_reg <= dsr_next;
        end
        if (load_out)
        begin
            raw_reg    <= gen_reg;
            empty_reg  <= (dsr_reg == '0);
            ranged_reg <= (dsr_reg == '0) ? begin_reg : begin_reg + div_rem;
        end
    end

    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign raw_value    = raw_reg;
    assign ranged_value = ranged_reg;
    assign range_empty  = empty_reg;

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in |=> !in_ready && (state_reg == lcgrr_pkg::ST_MUL))
        else $error("sequencer did not leave idle after accepting an item");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> (state_reg == lcgrr_pkg::ST_DIV))
        else $error("remainder unit finished outside the divide step");

    a_div_runs_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lcgrr_pkg::ST_DIV) && !div_status.done |-> div_status.busy)
        else $error("divide step waiting on an idle remainder unit");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid && (raw_value == $past(gen_reg)))
        else $error("output register did not take the finished item");
`endif

endmodule
